@@ design/zbh_pkg.sv @@
// shared types and constants of the zobrist board hash
`default_nettype none
package zbh_pkg;

	localparam int PieceTypes   = 13;
	localparam int BoardSquares = 64;
	localparam int CastleKeys   = 16;
	localparam int EpKeys       = 9;

	localparam int SquareW  = 6;
	localparam int PieceW   = 4;
	localparam int CastleW  = 4;
	localparam int EpW      = 7;
	localparam int EpSlotW  = $clog2(EpKeys);
	localparam int IdxW     = SquareW + PieceW;
	localparam int HashW    = 64;
	localparam int InDataW  = 24;
	localparam int OutDataW = 64;

	// accumulator memory
	localparam int AccDepth = 2;
	localparam int AccAddrW = $clog2(AccDepth);
	localparam logic [AccAddrW-1:0] AccAddr = '0;

	localparam logic [HashW-1:0] KeyMult = 64'd12345321971238532197;
	localparam int KeyBase = PieceTypes * BoardSquares;
	localparam logic [HashW-1:0] KeyWhite  = KeyMult * 64'(KeyBase);
	localparam logic [HashW-1:0] KeyCastle = KeyMult * 64'(KeyBase + 1);
	localparam logic [HashW-1:0] KeyEp     = KeyMult * 64'(KeyBase + 1 + CastleKeys);

	typedef struct packed {
		logic                last;
		logic                white;
		logic [CastleW-1:0]  castle;
		logic [EpSlotW-1:0]  ep_slot;
		logic [IdxW-1:0]     idx;
	} item_t;

endpackage
`default_nettype wire

@@ design/zobrist_board_hash.sv @@
// top level of the zobrist board hash
//
// Input channel s_*: one beat per board square. tdata carries square, piece
// code, side to move, castle mask and en-passant square; tlast marks the final
// square of a position, and only then do the side fields count.
// Output channel m_*: one beat per position, tdata is the 64-bit hash.
// A beat accepted on s_* is registered into stage 1, then into the hash stage;
// a position's hash then goes into the output register that drives m_tvalid.
// One square per cycle unless the output stalls: the accumulator lives in
// a registered-read memory that is read every cycle and written by the hash
// stage, with the value written in the previous cycle forwarded around it.
// The output register holds a hash while m_tready is low; squares keep
// flowing until a second hash would have to leave, then s_tready drops.
// After reset the accumulator reads as zero until its first write; the block
// accepts beats from the first cycle after reset, no clearing pass is needed.
// After every tlast beat the accumulator goes back to zero.
`default_nettype none
module zobrist_board_hash (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// square[5:0], piece_code[9:6], white_to_move[10], castle_rights[14:11],
	// ep_square[21:15], zero[23:22]
	input  wire logic [zbh_pkg::InDataW-1:0]   s_tdata,
	input  wire logic                          s_tlast,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// hash[63:0]
	output logic      [zbh_pkg::OutDataW-1:0]  m_tdata
);

	logic [zbh_pkg::SquareW-1:0] in_square;
	logic [zbh_pkg::PieceW-1:0]  in_piece;
	logic [zbh_pkg::PieceW-1:0]  piece_ok;
	logic [zbh_pkg::EpW-1:0]     in_ep;
	zbh_pkg::item_t              in_item;

	logic                        s1_valid_s1;
	zbh_pkg::item_t              item_s1;
	logic                        s2_valid_s2;
	zbh_pkg::item_t              item_s2;

	logic [zbh_pkg::HashW-1:0]   piece_key_s2;
	logic [zbh_pkg::HashW-1:0]   side_key_s2;

	logic                        adv_s1;
	logic                        adv_s2;
	logic                        ram_we;
	logic [zbh_pkg::HashW-1:0]   ram_wdata;
	logic [zbh_pkg::HashW-1:0]   ram_rdata;
	logic                        acc_valid_q;
	logic                        rd_ok_q;
	logic                        wr_last_q;
	logic [zbh_pkg::HashW-1:0]   wr_data_q;
	logic [zbh_pkg::HashW-1:0]   acc_cur;
	logic [zbh_pkg::HashW-1:0]   hash_next;
	logic                        out_valid_q;
	logic [zbh_pkg::HashW-1:0]   out_data_q;

	// unpack and index
	always_comb begin
		in_square = s_tdata[5:0];
		in_piece  = s_tdata[9:6];
		in_ep     = s_tdata[21:15];
		piece_ok  = ({1'b0, in_piece} >= (zbh_pkg::PieceW + 1)'(zbh_pkg::PieceTypes))
			? '0 : in_piece;
		in_item.last    = s_tlast;
		in_item.white   = s_tdata[10];
		in_item.castle  = s_tdata[14:11];
		in_item.ep_slot = in_ep[zbh_pkg::EpW-1] ? '0
			: zbh_pkg::EpSlotW'({1'b0, in_ep[2:0]}) + zbh_pkg::EpSlotW'(1);
		in_item.idx     = {piece_ok, in_square};
	end

	assign adv_s2   = !s2_valid_s2 || !item_s2.last || !out_valid_q || m_tready;
	assign adv_s1   = !s1_valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			s2_valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				s1_valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				s2_valid_s2 <= s1_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && adv_s1) begin
			item_s1 <= in_item;
		end
		if (s1_valid_s1 && adv_s2) begin
			item_s2 <= item_s1;
		end
	end

	zbh_keygen u_keygen (
		.clk          (clk),
		.en           (s1_valid_s1 && adv_s2),
		.item_s1      (item_s1),
		.piece_key_s2 (piece_key_s2),
		.side_key_s2  (side_key_s2)
	);

	// accumulator read-modify-write
	always_comb begin
		if (wr_last_q) begin
			acc_cur = wr_data_q;
		end else if (rd_ok_q) begin
			acc_cur = ram_rdata;
		end else begin
			acc_cur = '0;
		end
		hash_next = acc_cur ^ piece_key_s2 ^ (item_s2.last ? side_key_s2 : '0);
		ram_we    = s2_valid_s2 && adv_s2;
		ram_wdata = item_s2.last ? '0 : hash_next;
	end

	zbh_ram #(
		.Width (zbh_pkg::HashW),
		.Depth (zbh_pkg::AccDepth)
	) u_acc_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (zbh_pkg::AccAddr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_valid_q <= 1'b0;
			rd_ok_q     <= 1'b0;
			wr_last_q   <= 1'b0;
		end else begin
			acc_valid_q <= acc_valid_q || ram_we;
			rd_ok_q     <= acc_valid_q;
			wr_last_q   <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			wr_data_q <= ram_wdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ram_we && item_s2.last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we && item_s2.last) begin
			out_data_q <= hash_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef ASSERT_OFF
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && item_s2.last) |=> (wr_last_q && wr_data_q == '0))
		else $error("accumulator not cleared after last beat");

	a_out_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s2_valid_s2 && item_s2.last && adv_s2))
		else $error("hash emitted without a last beat");

	a_acc_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(acc_valid_q))
		else $error("accumulator valid dropped");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (s1_valid_s1 && s2_valid_s2 && item_s2.last && out_valid_q))
		else $error("input stalled without a full pipeline");

	a_no_write_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid_s2 && !adv_s2) |=> !wr_last_q)
		else $error("accumulator written by a stalled stage");
`endif

endmodule
`default_nettype wire

@@ design/zbh_ram.sv @@
// generic single-port ram with registered read
`default_nettype none
module zbh_ram #(
	parameter int Width = 64,
	parameter int Depth = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

@@ design/zbh_keygen.sv @@
// key multipliers: piece/square key and side key, registered into stage 2
`default_nettype none
module zbh_keygen (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire zbh_pkg::item_t            item_s1,
	output logic [zbh_pkg::HashW-1:0]      piece_key_s2,
	output logic [zbh_pkg::HashW-1:0]      side_key_s2
);

	logic [zbh_pkg::HashW-1:0] piece_key;
	logic [zbh_pkg::HashW-1:0] castle_key;
	logic [zbh_pkg::HashW-1:0] ep_key;
	logic [zbh_pkg::HashW-1:0] white_key;

	always_comb begin
		piece_key  = zbh_pkg::KeyMult * zbh_pkg::HashW'(item_s1.idx);
		castle_key = zbh_pkg::KeyCastle + zbh_pkg::KeyMult * zbh_pkg::HashW'(item_s1.castle);
		ep_key     = zbh_pkg::KeyEp + zbh_pkg::KeyMult * zbh_pkg::HashW'(item_s1.ep_slot);
		white_key  = item_s1.white ? zbh_pkg::KeyWhite : '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			piece_key_s2 <= piece_key;
			side_key_s2  <= castle_key ^ ep_key ^ white_key;
		end
	end

endmodule
`default_nettype wire

@@ dv/zobrist_board_hash_test.sv @@
// testbench of the zobrist board hash: directed positions, then random boards against a hash model
`default_nettype none
module zobrist_board_hash_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] KeyMul = 64'd12345321971238532197;
	localparam int KeyBase = zbh_pkg::PieceTypes * 64;
	localparam int RandItems = 1600;
	localparam int CalmItems = 1350;
	localparam int StallLimit = 1000;
	localparam int DirectedRows = 15;

	typedef struct packed {
		bit [5:0]  square;
		bit [3:0]  piece;
		bit        last;
		bit        white;
		bit [3:0]  castle;
		bit [6:0]  ep;
		bit        typed;
		bit [63:0] hash;
	} square_beat_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	// square[5:0], piece_code[9:6], white_to_move[10], castle_rights[14:11],
	// ep_square[21:15], zero[23:22]
	logic [zbh_pkg::InDataW-1:0]    s_tdata;
	logic                           s_tlast;
	logic                           m_tvalid;
	logic                           m_tready;
	// hash[63:0]
	logic [zbh_pkg::OutDataW-1:0]   m_tdata;

	logic                           row_typed;
	logic [63:0]                    row_hash;
	logic [63:0]                    board_acc = '0;
	logic [63:0]                    position_hashes[$];
	int                             mismatches;
	int                             dead_cycles;
	int                             tx_idle_pct;
	int                             rx_stall_pct;
	square_beat_t                   directed_rows[DirectedRows];

	zobrist_board_hash u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] zobrist_key(int unsigned n);
		return 64'(n) * KeyMul;
	endfunction

	// folds one square into the running hash; returns 1 with the hash on the final square
	function automatic bit fold_square(logic [5:0] square, logic [3:0] piece, logic last,
			logic white, logic [3:0] castle, logic [6:0] ep, output logic [63:0] hash);
		logic [3:0]  pc;
		logic [63:0] h;
		int          ep_slot;
		pc = (piece >= zbh_pkg::PieceTypes) ? 4'd0 : piece;
		h = board_acc ^ zobrist_key(32'({pc, square}));
		hash = h;
		if (!last) begin
			board_acc = h;
			return 1'b0;
		end
		if (white)
			h ^= zobrist_key(KeyBase);
		h ^= zobrist_key(KeyBase + 1 + int'(castle));
		ep_slot = ep[6] ? 0 : int'(ep[2:0]) + 1;
		h ^= zobrist_key(KeyBase + 17 + ep_slot);
		hash = h;
		board_acc = '0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at %0t: %s, got %h want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : monitor
		logic [63:0] h;
		logic [63:0] want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				if (fold_square(s_tdata[5:0], s_tdata[9:6], s_tlast, s_tdata[10],
						s_tdata[14:11], s_tdata[21:15], h))
					position_hashes.push_back(row_typed ? row_hash : h);
			end
			if (m_tvalid && m_tready) begin
				if (position_hashes.size() == 0) begin
					report_mismatch("hash beat with no position pending", m_tdata, 'x);
				end else begin
					want = position_hashes.pop_front();
					if (m_tdata !== want)
						report_mismatch("hash", m_tdata, want);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			dead_cycles <= 0;
		end else if (dead_cycles == StallLimit) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			dead_cycles <= dead_cycles + 1;
		end
	end

	initial begin : sink
		m_tready <= 1'b1;
		forever begin
			@(posedge clk);
			if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_square(square_beat_t b);
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, b.ep, b.castle, b.white, b.piece, b.square};
		s_tlast <= b.last;
		row_typed <= b.typed;
		row_hash <= b.hash;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_for_hashes();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (position_hashes.size() != 0);
	endtask

	initial begin : stimulus
		square_beat_t b;
		int           rand_items;
		int           len;
		int           shape;
		bit           calm;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		row_typed <= 1'b0;
		row_hash <= '0;
		tx_idle_pct = 20;
		rx_stall_pct = 20;
		rand_items = 0;

		// square, piece, last, white, castle, ep, typed, hash
		directed_rows = '{
			'{6'd0,  4'd0,  1'b1, 1'b0, 4'd0,  -7'sd1,  1'b1,
				zobrist_key(833) ^ zobrist_key(849)},
			'{6'd63, 4'd12, 1'b1, 1'b1, 4'd15, 7'sd63,  1'b1,
				zobrist_key(831) ^ zobrist_key(832) ^ zobrist_key(848) ^ zobrist_key(857)},
			// out-of-range piece hashes as empty
			'{6'd5,  4'd13, 1'b1, 1'b0, 4'd0,  -7'sd1,  1'b1,
				zobrist_key(5) ^ zobrist_key(833) ^ zobrist_key(849)},
			'{6'd63, 4'd15, 1'b1, 1'b1, 4'd0,  -7'sd64, 1'b1,
				zobrist_key(63) ^ zobrist_key(832) ^ zobrist_key(833) ^ zobrist_key(849)},
			// repeated square cancels, side fields ignored before the final square
			'{6'd10, 4'd1,  1'b0, 1'b1, 4'd15, 7'sd63,  1'b0, 64'd0},
			'{6'd10, 4'd1,  1'b0, 1'b0, 4'd0,  7'sd0,   1'b0, 64'd0},
			'{6'd0,  4'd0,  1'b1, 1'b0, 4'd1,  7'sd0,   1'b1,
				zobrist_key(834) ^ zobrist_key(850)},
			'{6'd7,  4'd6,  1'b0, 1'b0, 4'd0,  -7'sd1,  1'b0, 64'd0},
			'{6'd56, 4'd12, 1'b0, 1'b1, 4'd7,  7'sd12,  1'b0, 64'd0},
			'{6'd63, 4'd14, 1'b0, 1'b0, 4'd0,  -7'sd64, 1'b0, 64'd0},
			'{6'd32, 4'd0,  1'b1, 1'b1, 4'd2,  7'sd8,   1'b0, 64'd0},
			'{6'd1,  4'd3,  1'b1, 1'b0, 4'd4,  7'sd23,  1'b0, 64'd0},
			'{6'd2,  4'd9,  1'b0, 1'b1, 4'd3,  -7'sd33, 1'b0, 64'd0},
			'{6'd3,  4'd11, 1'b1, 1'b1, 4'd8,  7'sd47,  1'b0, 64'd0},
			'{6'd60, 4'd7,  1'b1, 1'b1, 4'd5,  7'sd42,  1'b0, 64'd0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			send_square(directed_rows[r]);
		wait_for_hashes();

		while (rand_items < RandItems) begin
			calm = rand_items >= CalmItems;
			case ($urandom_range(0, 3))
				0: tx_idle_pct = 0;
				1: tx_idle_pct = 5;
				2: tx_idle_pct = 25;
				default: tx_idle_pct = 60;
			endcase
			case ($urandom_range(0, 3))
				0: rx_stall_pct = 0;
				1: rx_stall_pct = 5;
				2: rx_stall_pct = 25;
				default: rx_stall_pct = 60;
			endcase
			if (calm) begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end else if ($urandom_range(0, 9) == 0) begin
				wait_for_hashes();
			end
			shape = $urandom_range(0, 9);
			case (shape)
				0, 1, 2: len = 64;
				3, 4, 5, 6, 7: len = $urandom_range(1, 16);
				8: len = 1;
				default: len = $urandom_range(17, 64);
			endcase
			for (int i = 0; i < len; i++) begin
				// full boards walk the squares in order, the rest hit any square
				b.square = (shape <= 2) ? 6'(i) : 6'($urandom_range(0, 63));
				b.piece = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(13, 15))
					: 4'($urandom_range(0, 12));
				b.last = (i == len - 1);
				b.white = 1'($urandom_range(0, 1));
				b.castle = 4'($urandom_range(0, 15));
				case ($urandom_range(0, 2))
					0: b.ep = -7'sd1;
					1: b.ep = 7'($urandom_range(0, 63));
					default: b.ep = 7'($urandom_range(0, 127));
				endcase
				b.typed = 1'b0;
				b.hash = '0;
				send_square(b);
				rand_items++;
			end
		end

		wait_for_hashes();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire

@@ files.f @@
design/zbh_pkg.sv
design/zbh_ram.sv
design/zbh_keygen.sv
design/zobrist_board_hash.sv
dv/zobrist_board_hash_test.sv
